[rtl/spfr_pkg.sv]
package spfr_pkg;

  localparam int FRAMES          = 16;
  localparam int PAGES_PER_SPACE = 32;
  localparam int SPACES          = 8;

  // item field widths
  localparam int CMD_W   = 1;
  localparam int ID_W    = $clog2(SPACES + 1);
  localparam int PAGE_W  = $clog2(PAGES_PER_SPACE);
  localparam int FRAME_W = 4;

  // internal frame index width
  localparam int FRAME_IDX_W = $clog2(FRAMES);

  localparam logic [CMD_W-1:0] CMD_FAULT   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

  typedef logic [FRAME_IDX_W-1:0] frame_idx_t;

  typedef struct packed {
    logic              wr_en;
    frame_idx_t        wr_frame;
    logic [ID_W-1:0]   wr_owner;
    logic [PAGE_W-1:0] wr_page;
    logic              clr_en;
    frame_idx_t        clr_frame;
    frame_idx_t        rd_frame;
    frame_idx_t        scan_frame;
  } tbl_ctrl_t;

  typedef struct packed {
    logic [FRAME_W-1:0] chosen_frame;
    logic               must_evict;
    logic [ID_W-1:0]    evicted_space_id;
    logic [PAGE_W-1:0]  evicted_page;
  } result_t;

endpackage

[rtl/spfr_chan_if.sv]
interface spfr_req_if;
  logic                          valid;
  logic                          ready;
  logic [spfr_pkg::CMD_W-1:0]    cmd;
  logic [spfr_pkg::ID_W-1:0]     space_id;
  logic [spfr_pkg::PAGE_W-1:0]   page_number;
  logic [spfr_pkg::FRAME_W-1:0]  frame_to_free;

  modport source (output valid, cmd, space_id, page_number, frame_to_free, input ready);
  modport sink (input valid, cmd, space_id, page_number, frame_to_free, output ready);
endinterface

interface spfr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [spfr_pkg::FRAME_W-1:0]  chosen_frame;
  logic                          must_evict;
  logic [spfr_pkg::ID_W-1:0]     evicted_space_id;
  logic [spfr_pkg::PAGE_W-1:0]   evicted_page;

  modport source (output valid, chosen_frame, must_evict, evicted_space_id, evicted_page,
                  input ready);
  modport sink (input valid, chosen_frame, must_evict, evicted_space_id, evicted_page,
                output ready);
endinterface

[rtl/spfr_frame_table.sv]
module spfr_frame_table (
  input  logic                        clk,
  input  logic                        rst,
  input  spfr_pkg::tbl_ctrl_t         ctrl,
  output logic                        scan_valid,
  output logic                        rd_valid,
  output logic [spfr_pkg::ID_W-1:0]   rd_owner,
  output logic [spfr_pkg::PAGE_W-1:0] rd_page
);

  logic [spfr_pkg::FRAMES-1:0] valid_bits;
  logic [spfr_pkg::ID_W-1:0]   owner_mem [spfr_pkg::FRAMES];
  logic [spfr_pkg::PAGE_W-1:0] page_mem  [spfr_pkg::FRAMES];

  assign scan_valid = valid_bits[ctrl.scan_frame];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else begin
      if (ctrl.clr_en) begin
        valid_bits[ctrl.clr_frame] <= 1'b0;
      end
      if (ctrl.wr_en) begin
        valid_bits[ctrl.wr_frame] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      owner_mem[ctrl.wr_frame] <= ctrl.wr_owner;
      page_mem[ctrl.wr_frame]  <= ctrl.wr_page;
    end
    rd_owner <= owner_mem[ctrl.rd_frame];
    rd_page  <= page_mem[ctrl.rd_frame];
    rd_valid <= valid_bits[ctrl.rd_frame];
  end

endmodule

[rtl/spfr_scan_ctrl.sv]
module spfr_scan_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [spfr_pkg::CMD_W-1:0]   req_cmd,
  input  logic [spfr_pkg::ID_W-1:0]    req_space_id,
  input  logic [spfr_pkg::PAGE_W-1:0]  req_page_number,
  input  logic [spfr_pkg::FRAME_W-1:0] req_frame_to_free,
  output spfr_pkg::tbl_ctrl_t          ctrl,
  input  logic                         scan_valid,
  input  logic                         rd_valid,
  input  logic [spfr_pkg::ID_W-1:0]    rd_owner,
  input  logic [spfr_pkg::PAGE_W-1:0]  rd_page,
  output logic                         res_valid,
  input  logic                         res_ready,
  output spfr_pkg::result_t            res
);

  localparam int SUM_W = spfr_pkg::FRAME_IDX_W + 1;
  localparam logic [SUM_W-1:0] FRAMES_S = SUM_W'(spfr_pkg::FRAMES);
  localparam spfr_pkg::frame_idx_t LAST_STEP = spfr_pkg::FRAME_IDX_W'(spfr_pkg::FRAMES - 1);
  localparam spfr_pkg::frame_idx_t ONE_STEP  = spfr_pkg::FRAME_IDX_W'(1);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    WRAP,
    READ,
    EMIT
  } state_t;

  state_t                      state;
  spfr_pkg::frame_idx_t        ptr;
  spfr_pkg::frame_idx_t        step;
  spfr_pkg::frame_idx_t        chosen;
  logic [spfr_pkg::ID_W-1:0]   id_q;
  logic [spfr_pkg::PAGE_W-1:0] page_q;

  logic [SUM_W-1:0]     sum;
  spfr_pkg::frame_idx_t idx;
  logic                 accept;
  logic                 release_hit;

  // shared circular index unit: ptr + step modulo the frame count
  assign sum = {1'b0, ptr} + {1'b0, step};
  assign idx = (sum >= FRAMES_S) ? spfr_pkg::FRAME_IDX_W'(sum - FRAMES_S)
                                 : spfr_pkg::FRAME_IDX_W'(sum);

  assign req_ready   = (state == IDLE);
  assign accept      = req_valid && req_ready;
  assign release_hit = accept && (req_cmd == spfr_pkg::CMD_RELEASE) &&
                       (int'(req_frame_to_free) < spfr_pkg::FRAMES);

  assign res_valid = (state == EMIT);

  always_comb begin
    res.chosen_frame     = spfr_pkg::FRAME_W'(chosen);
    res.must_evict       = rd_valid;
    res.evicted_space_id = rd_valid ? rd_owner : '0;
    res.evicted_page     = rd_valid ? rd_page : '0;
  end

  always_comb begin
    ctrl.wr_en      = (state == EMIT) && res_ready;
    ctrl.wr_frame   = chosen;
    ctrl.wr_owner   = id_q;
    ctrl.wr_page    = page_q;
    ctrl.clr_en     = release_hit;
    ctrl.clr_frame  = spfr_pkg::FRAME_IDX_W'(req_frame_to_free);
    ctrl.rd_frame   = chosen;
    ctrl.scan_frame = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      ptr    <= '0;
      step   <= '0;
      chosen <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (accept && (req_cmd == spfr_pkg::CMD_FAULT)) begin
            id_q   <= req_space_id;
            page_q <= req_page_number;
            step   <= '0;
            state  <= SCAN;
          end
        end
        SCAN: begin
          if (!scan_valid) begin
            chosen <= idx;
            state  <= READ;
          end else if (step == LAST_STEP) begin
            // every frame taken: fall back to the frame after the pointer
            step  <= ONE_STEP;
            state <= WRAP;
          end else begin
            step <= step + ONE_STEP;
          end
        end
        WRAP: begin
          chosen <= idx;
          state  <= READ;
        end
        READ: begin
          state <= EMIT;
        end
        EMIT: begin
          if (res_ready) begin
            ptr   <= chosen;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_no_clear_during_write: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.wr_en && ctrl.clr_en))
    else $error("frame write and release clear in the same cycle");

  a_ptr_follows_write: assert property (@(posedge clk) disable iff (rst)
    ctrl.wr_en |=> (ptr == $past(ctrl.wr_frame)))
    else $error("pointer did not move to the written frame");

  a_chosen_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (int'(chosen) < spfr_pkg::FRAMES))
    else $error("chosen frame out of range");

  a_free_result_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.must_evict) |->
      (res.evicted_space_id == '0 && res.evicted_page == '0))
    else $error("eviction fields set for a free frame");

  a_wrap_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == WRAP) |-> ($past(state) == SCAN && $past(step) == LAST_STEP))
    else $error("fallback taken before a full scan");

endmodule

[rtl/swap_pool_frame_replacer.sv]
// channel | dir | handshake     | payload
// req     | in  | valid / ready | cmd, space_id, page_number, frame_to_free
// rsp     | out | valid / ready | chosen_frame, must_evict, evicted_space_id, evicted_page
//
// a release item gives no item on rsp
// a fault scans up to FRAMES frames, one frame a cycle from the pointer, until a free one is
//   found; when all frames are taken it falls back to the frame after the pointer, then it
//   reads the table and loads the result
// the scan sequencer has a single circular adder, shared by the scan and the fallback
// rst is synchronous: all frames free, pointer at frame zero, no result held
// a result waits in the output register; a new item is taken meanwhile, and a fault
//   that finishes while it still waits holds until rsp takes the older one
module swap_pool_frame_replacer (
  input logic        clk,
  input logic        rst,
  spfr_req_if.sink   req,
  spfr_rsp_if.source rsp
);

  spfr_pkg::tbl_ctrl_t         ctrl;
  spfr_pkg::result_t           res;
  logic                        res_valid;
  logic                        res_ready;
  logic                        scan_valid;
  logic                        rd_valid;
  logic [spfr_pkg::ID_W-1:0]   rd_owner;
  logic [spfr_pkg::PAGE_W-1:0] rd_page;

  logic              out_valid;
  spfr_pkg::result_t out_q;

  spfr_frame_table u_table (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .scan_valid (scan_valid),
    .rd_valid   (rd_valid),
    .rd_owner   (rd_owner),
    .rd_page    (rd_page)
  );

  spfr_scan_ctrl u_scan (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_cmd           (req.cmd),
    .req_space_id      (req.space_id),
    .req_page_number   (req.page_number),
    .req_frame_to_free (req.frame_to_free),
    .ctrl              (ctrl),
    .scan_valid        (scan_valid),
    .rd_valid          (rd_valid),
    .rd_owner          (rd_owner),
    .rd_page           (rd_page),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res               (res)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.chosen_frame     = out_q.chosen_frame;
  assign rsp.must_evict       = out_q.must_evict;
  assign rsp.evicted_space_id = out_q.evicted_space_id;
  assign rsp.evicted_page     = out_q.evicted_page;

endmodule
